// ===== hdl/dlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants of the detection leader clustering block
// cluster record, search item, table write command and code values
// ----------------------------------------------------------------------------
package dlc_pkg;

	localparam int MAX_CLUSTERS   = 16;
	localparam int IDX_W          = $clog2(MAX_CLUSTERS);
	localparam int OPEN_W         = $clog2(MAX_CLUSTERS + 1);
	localparam int MAX_DETECTIONS = 1024;
	localparam int CNT_W          = $clog2(MAX_DETECTIONS + 1);
	localparam int DIV_STEPS      = 21;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

	// status codes
	localparam logic [1:0] ST_JOIN  = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_FRAME = 2'd3;

	// register indexes
	localparam logic REG_MAX_CLUSTERS = 1'b0;
	localparam logic REG_JOIN_DIST    = 1'b1;

	typedef struct packed {
		logic [10:0] cen_x;
		logic [10:0] cen_y;
		logic [7:0]  min_r;
		logic [7:0]  max_r;
		logic [10:0] members;
		logic [20:0] sum_x;
		logic [20:0] sum_y;
		logic [17:0] err_sum;
		logic [17:0] rad_sum;
	} rec_t;

	// item walking down the cell row
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic [10:0]      x;
		logic [10:0]      y;
		logic [7:0]       r;
		logic [7:0]       e;
		rec_t             rec;
	} tok_t;

	// table write: open a new entry or store a fresh centroid
	typedef struct packed {
		logic             new_en;
		logic             cen_en;
		logic [IDX_W-1:0] idx;
		logic [10:0]      x;
		logic [10:0]      y;
		logic [7:0]       r;
		logic [7:0]       e;
	} wr_t;

endpackage

// ===== hdl/dlc_if.sv =====
// ----------------------------------------------------------------------------
// dlc_if: handshake channels of the detection leader clustering block
// detection input, cluster result output and register write port
// ----------------------------------------------------------------------------
interface det_if;
	logic        valid;
	logic        ready;
	logic [10:0] det_x;
	logic [10:0] det_y;
	logic [7:0]  det_radius;
	logic [7:0]  det_error;
	logic        last_of_frame;

	modport source (output valid, det_x, det_y, det_radius, det_error, last_of_frame,
		input ready);
	modport sink (input valid, det_x, det_y, det_radius, det_error, last_of_frame,
		output ready);
endinterface

interface res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  cluster_index;
	logic [4:0]  cluster_count;
	logic [10:0] centroid_x;
	logic [10:0] centroid_y;
	logic [7:0]  min_radius;
	logic [7:0]  max_radius;
	logic [10:0] member_count;
	logic [17:0] error_sum;
	logic [17:0] radius_sum;

	modport source (output valid, status, cluster_index, cluster_count, centroid_x,
		centroid_y, min_radius, max_radius, member_count, error_sum, radius_sum,
		input ready);
	modport sink (input valid, status, cluster_index, cluster_count, centroid_x,
		centroid_y, min_radius, max_radius, member_count, error_sum, radius_sum,
		output ready);
endinterface

interface cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/dlc_cell.sv =====
// ----------------------------------------------------------------------------
// dlc_cell: one cluster table entry
// compares the passing item against its centroid, joins it on first match
// ----------------------------------------------------------------------------
module dlc_cell
	import dlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             active,
	input  logic [15:0]      join_dist,
	input  tok_t             tok_in,
	input  wr_t              wr,
	output tok_t             tok_out
);

	rec_t        rec_q;
	rec_t        upd;
	tok_t        tok_q;
	tok_t        tok_nx;
	logic [10:0] dx;
	logic [10:0] dy;
	logic [21:0] sq_x;
	logic [21:0] sq_y;
	logic [22:0] sq_dist;
	logic        hit_here;
	logic [21:0] sx;
	logic [21:0] sy;
	logic [11:0] sm;
	logic [18:0] se;
	logic [18:0] sr;

	always_comb begin
		dx = (rec_q.cen_x > tok_in.x) ? rec_q.cen_x - tok_in.x : tok_in.x - rec_q.cen_x;
		dy = (rec_q.cen_y > tok_in.y) ? rec_q.cen_y - tok_in.y : tok_in.y - rec_q.cen_y;
		sq_x = 22'(dx) * 22'(dx);
		sq_y = 22'(dy) * 22'(dy);
		sq_dist = {1'b0, sq_x} + {1'b0, sq_y};
		hit_here = tok_in.vld && !tok_in.hit && active && (sq_dist <= 23'(join_dist));
	end

	// joined record, sums saturate at their widths
	always_comb begin
		upd = rec_q;
		if (tok_in.r > rec_q.max_r) begin
			upd.max_r = tok_in.r;
		end else if (tok_in.r < rec_q.min_r) begin
			upd.min_r = tok_in.r;
		end
		sx = {1'b0, rec_q.sum_x} + 22'(tok_in.x);
		sy = {1'b0, rec_q.sum_y} + 22'(tok_in.y);
		sm = {1'b0, rec_q.members} + 12'd1;
		se = {1'b0, rec_q.err_sum} + 19'(tok_in.e);
		sr = {1'b0, rec_q.rad_sum} + 19'(tok_in.r);
		upd.sum_x   = sx[21] ? '1 : sx[20:0];
		upd.sum_y   = sy[21] ? '1 : sy[20:0];
		upd.members = sm[11] ? '1 : sm[10:0];
		upd.err_sum = se[18] ? '1 : se[17:0];
		upd.rad_sum = sr[18] ? '1 : sr[17:0];
	end

	// item handed to the next cell, tagged with this entry on a hit
	always_comb begin
		tok_nx = tok_in;
		if (hit_here) begin
			tok_nx.hit = 1'b1;
			tok_nx.idx = cell_idx;
			tok_nx.rec = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_here) begin
			rec_q <= upd;
		end else if (wr.new_en && wr.idx == cell_idx) begin
			rec_q.cen_x   <= wr.x;
			rec_q.cen_y   <= wr.y;
			rec_q.min_r   <= wr.r;
			rec_q.max_r   <= wr.r;
			rec_q.members <= 11'd1;
			rec_q.sum_x   <= 21'(wr.x);
			rec_q.sum_y   <= 21'(wr.y);
			rec_q.err_sum <= 18'(wr.e);
			rec_q.rad_sum <= 18'(wr.r);
		end else if (wr.cen_en && wr.idx == cell_idx) begin
			rec_q.cen_x <= wr.x;
			rec_q.cen_y <= wr.y;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hdl/dlc_div.sv =====
// ----------------------------------------------------------------------------
// dlc_div: restoring divider for the centroid
// 21-bit sum over 11-bit member count, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dlc_div
	import dlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [20:0] dividend,
	input  logic [10:0] divisor,
	output logic        done,
	output logic [10:0] quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [10:0]          rem_q;
	logic [20:0]          quo_q;
	logic [10:0]          div_q;
	logic [11:0]          trial;
	logic                 ge;
	logic [11:0]          diff;

	always_comb begin
		trial = {rem_q, quo_q[20]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[10:0] : trial[10:0];
			quo_q <= {quo_q[19:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[10:0];

endmodule

// ===== hdl/detection_leader_clustering.sv =====
// ----------------------------------------------------------------------------
// detection_leader_clustering: online leader clustering of circle detections
// frame-wise cluster table as a row of cells with an x and a y centroid divider
// ----------------------------------------------------------------------------
// One item is taken at a time. An accepted detection walks down a row of 16
// cells, one cell per cycle; each cell holds one table entry and the first open
// entry whose squared distance to the item is at most join_dist takes the item
// and updates its record. A joined item then waits for the two restoring
// dividers, stepping through all bits of the 21-bit sum, that recompute the
// centroid; a new cluster needs only the walk, and an item dropped at the frame
// limit or after the table has filled goes straight to the output register,
// once it is free. The next item is taken at the edge after the previous result
// has moved into the output register. Table entries need no clearing: only
// entries below the open count take part.
module detection_leader_clustering
	import dlc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	det_if.sink   det,
	res_if.source res,
	cfg_if.sink   cfg
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0]       state_q;
	logic [OPEN_W-1:0] open_q;
	logic             halted_q;
	logic [CNT_W-1:0] det_cnt_q;
	logic [4:0]       cfg_max_q;
	logic [15:0]      cfg_join_q;
	logic             launch_q;
	logic             wr_new_q;
	logic             wr_cen_q;
	logic             div_start_q;
	logic             out_vld_q;

	// latched item
	logic [10:0] x_q;
	logic [10:0] y_q;
	logic [7:0]  r_q;
	logic [7:0]  e_q;
	logic        last_q;

	// result being built
	logic [1:0]       res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [4:0]       res_count_q;
	rec_t             res_rec_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [10:0]      wr_x_q;
	logic [10:0]      wr_y_q;

	// output register
	logic [1:0]  o_status_q;
	logic [3:0]  o_idx_q;
	logic [4:0]  o_count_q;
	rec_t        o_rec_q;

	tok_t             chain [0:MAX_CLUSTERS];
	tok_t             head;
	wr_t              wr;
	logic [OPEN_W-1:0] limit;
	logic             acc;
	logic             at_limit;
	logic             chain_done;
	logic             full;
	logic             div_done;
	logic             div_done_y;
	logic [10:0]      quo_x;
	logic [10:0]      quo_y;
	logic             out_load;

	assign limit      = (cfg_max_q > 5'(MAX_CLUSTERS)) ? OPEN_W'(MAX_CLUSTERS)
		: OPEN_W'(cfg_max_q);
	assign det.ready  = (state_q == S_IDLE);
	assign acc        = det.valid && det.ready;
	assign at_limit   = det_cnt_q >= CNT_W'(MAX_DETECTIONS);
	assign chain_done = (state_q == S_SEARCH) && chain[MAX_CLUSTERS].vld;
	assign full       = open_q >= limit;
	assign out_load   = (state_q == S_OUT) && (!out_vld_q || res.ready);
	assign cfg.ready  = 1'b1;

	// item enters the row from the latched detection
	always_comb begin
		head     = '0;
		head.vld = launch_q;
		head.x   = x_q;
		head.y   = y_q;
		head.r   = r_q;
		head.e   = e_q;
	end

	assign chain[0] = head;

	always_comb begin
		wr        = '0;
		wr.new_en = wr_new_q;
		wr.cen_en = wr_cen_q;
		wr.idx    = wr_idx_q;
		wr.x      = wr_x_q;
		wr.y      = wr_y_q;
		wr.r      = r_q;
		wr.e      = e_q;
	end

	// cluster table as a row of cells
	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		dlc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (IDX_W'(i)),
			.active    (OPEN_W'(i) < open_q),
			.join_dist (cfg_join_q),
			.tok_in    (chain[i]),
			.wr        (wr),
			.tok_out   (chain[i+1])
		);
	end

	// centroid dividers, both start and finish together
	dlc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (res_rec_q.sum_x),
		.divisor  (res_rec_q.members),
		.done     (div_done),
		.quotient (quo_x)
	);

	dlc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (res_rec_q.sum_y),
		.divisor  (res_rec_q.members),
		.done     (div_done_y),
		.quotient (quo_y)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			halted_q    <= 1'b0;
			det_cnt_q   <= '0;
			cfg_max_q   <= 5'd16;
			cfg_join_q  <= 16'd16;
			launch_q    <= 1'b0;
			wr_new_q    <= 1'b0;
			wr_cen_q    <= 1'b0;
			div_start_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			launch_q    <= 1'b0;
			wr_new_q    <= 1'b0;
			wr_cen_q    <= 1'b0;
			div_start_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					REG_MAX_CLUSTERS: cfg_max_q  <= cfg.data[4:0];
					REG_JOIN_DIST:    cfg_join_q <= cfg.data;
					default: ;
				endcase
			end
			// a load refills the output register in the cycle it drains
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (at_limit) begin
							state_q <= S_OUT;
						end else begin
							det_cnt_q <= det_cnt_q + 1'b1;
							if (halted_q) begin
								state_q <= S_OUT;
							end else begin
								launch_q <= 1'b1;
								state_q  <= S_SEARCH;
							end
						end
					end
				end
				S_SEARCH: begin
					if (chain_done) begin
						if (chain[MAX_CLUSTERS].hit) begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end else if (full) begin
							halted_q <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							wr_new_q <= 1'b1;
							open_q   <= open_q + 1'b1;
							state_q  <= S_OUT;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						wr_cen_q <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						// frame end clears the table
						if (last_q) begin
							open_q    <= '0;
							halted_q  <= 1'b0;
							det_cnt_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q          <= det.det_x;
			y_q          <= det.det_y;
			r_q          <= det.det_radius;
			e_q          <= det.det_error;
			last_q       <= det.last_of_frame;
			res_status_q <= at_limit ? ST_FRAME : ST_FULL;
			res_idx_q    <= '0;
			res_rec_q    <= '0;
			res_count_q  <= 5'(open_q);
		end
		if (chain_done) begin
			if (chain[MAX_CLUSTERS].hit) begin
				res_status_q <= ST_JOIN;
				res_idx_q    <= chain[MAX_CLUSTERS].idx;
				res_rec_q    <= chain[MAX_CLUSTERS].rec;
			end else if (!full) begin
				res_status_q      <= ST_NEW;
				res_idx_q         <= open_q[IDX_W-1:0];
				res_count_q       <= 5'(open_q) + 5'd1;
				res_rec_q.cen_x   <= x_q;
				res_rec_q.cen_y   <= y_q;
				res_rec_q.min_r   <= r_q;
				res_rec_q.max_r   <= r_q;
				res_rec_q.members <= 11'd1;
				res_rec_q.sum_x   <= 21'(x_q);
				res_rec_q.sum_y   <= 21'(y_q);
				res_rec_q.err_sum <= 18'(e_q);
				res_rec_q.rad_sum <= 18'(r_q);
				wr_idx_q          <= open_q[IDX_W-1:0];
				wr_x_q            <= x_q;
				wr_y_q            <= y_q;
			end
		end
		if (div_done) begin
			res_rec_q.cen_x <= quo_x;
			res_rec_q.cen_y <= quo_y;
			wr_idx_q        <= res_idx_q;
			wr_x_q          <= quo_x;
			wr_y_q          <= quo_y;
		end
		if (out_load) begin
			o_status_q <= res_status_q;
			o_idx_q    <= 4'(res_idx_q);
			o_count_q  <= res_count_q;
			o_rec_q    <= res_rec_q;
		end
	end

	assign res.valid         = out_vld_q;
	assign res.status        = o_status_q;
	assign res.cluster_index = o_idx_q;
	assign res.cluster_count = o_count_q;
	assign res.centroid_x    = o_rec_q.cen_x;
	assign res.centroid_y    = o_rec_q.cen_y;
	assign res.min_radius    = o_rec_q.min_r;
	assign res.max_radius    = o_rec_q.max_r;
	assign res.member_count  = o_rec_q.members;
	assign res.error_sum     = o_rec_q.err_sum;
	assign res.radius_sum    = o_rec_q.rad_sum;

	// open count never passes the table size
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OPEN_W'(MAX_CLUSTERS))
		else $error("open cluster count beyond table size");

	// an item leaves the cell row only while a search is running
	a_chain_state: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_CLUSTERS].vld |-> state_q == S_SEARCH)
		else $error("cell row output outside search");

	// both dividers finish together and only while waiting on them
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done || div_done_y) |-> (div_done && div_done_y && state_q == S_DIV))
		else $error("divider done out of step");

	// a loaded result shows up on the output
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> res.valid)
		else $error("result not presented after load");

endmodule

// ===== bench/detection_leader_clustering_tb.sv =====
// ----------------------------------------------------------------------------
// detection_leader_clustering_tb: self-checking bench of the clustering block
// directed table then random frames, all results checked against a predictor
// ----------------------------------------------------------------------------
module detection_leader_clustering_tb
	import dlc_pkg::*;
();

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	det_if det ();
	res_if res ();
	cfg_if cfg ();

	detection_leader_clustering i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.det    (det.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	always #2 clk = ~clk;

	// detection item and cluster result as seen by the bench
	typedef struct {
		logic [10:0] x;
		logic [10:0] y;
		logic [7:0]  r;
		logic [7:0]  e;
		logic        last;
	} det_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  index;
		logic [4:0]  count;
		logic [10:0] cen_x;
		logic [10:0] cen_y;
		logic [7:0]  min_r;
		logic [7:0]  max_r;
		logic [10:0] members;
		logic [17:0] err_sum;
		logic [17:0] rad_sum;
	} clres_t;

	// directed row: detection plus optional typed-in expectation
	typedef struct {
		det_t   d;
		logic   known;
		clres_t want;
	} row_t;

	// predictor state: shadow cluster table and frame counters
	logic [4:0]  pm_max_clusters = 5'd16;
	logic [15:0] pm_join_dist = 16'd16;
	logic [10:0] tb_cen_x [MAX_CLUSTERS];
	logic [10:0] tb_cen_y [MAX_CLUSTERS];
	logic [7:0]  tb_min_r [MAX_CLUSTERS];
	logic [7:0]  tb_max_r [MAX_CLUSTERS];
	logic [10:0] tb_members [MAX_CLUSTERS];
	logic [20:0] tb_sum_x [MAX_CLUSTERS];
	logic [20:0] tb_sum_y [MAX_CLUSTERS];
	logic [17:0] tb_err [MAX_CLUSTERS];
	logic [17:0] tb_rad [MAX_CLUSTERS];
	int unsigned open_cnt = 0;
	bit          halted = 0;
	int unsigned frame_dets = 0;

	clres_t pending_results [$];
	int     fail_count = 0;
	int     idle_cycles = 0;
	bit     stim_done = 0;
	bit     hold_sink = 0;

	function automatic logic [20:0] sat21(logic [20:0] a, logic [10:0] b);
		logic [21:0] s;
		s = 22'(a) + 22'(b);
		return s[21] ? 21'h1FFFFF : s[20:0];
	endfunction

	function automatic logic [17:0] sat18(logic [17:0] a, logic [7:0] b);
		logic [18:0] s;
		s = 19'(a) + 19'(b);
		return s[18] ? 18'h3FFFF : s[17:0];
	endfunction

	function automatic void fill_cluster(ref clres_t o, input int c);
		o.index   = c[3:0];
		o.cen_x   = tb_cen_x[c];
		o.cen_y   = tb_cen_y[c];
		o.min_r   = tb_min_r[c];
		o.max_r   = tb_max_r[c];
		o.members = tb_members[c];
		o.err_sum = tb_err[c];
		o.rad_sum = tb_rad[c];
	endfunction

	// computes the clustering result for one detection and advances the table
	function automatic clres_t cluster_step(det_t d);
		clres_t o;
		int unsigned lim, dx, dy;
		int c;
		bit hit;
		o = '{default: '0};
		lim = (pm_max_clusters > 5'(MAX_CLUSTERS)) ? 32'(MAX_CLUSTERS)
			: 32'(pm_max_clusters);
		hit = 0;
		c = 0;
		if (frame_dets >= MAX_DETECTIONS) begin
			o.status = ST_FRAME;
		end else begin
			frame_dets++;
			if (halted) begin
				o.status = ST_FULL;
			end else begin
				for (int k = 0; k < open_cnt && !hit; k++) begin
					dx = 32'((tb_cen_x[k] > d.x) ? tb_cen_x[k] - d.x : d.x - tb_cen_x[k]);
					dy = 32'((tb_cen_y[k] > d.y) ? tb_cen_y[k] - d.y : d.y - tb_cen_y[k]);
					if (dx * dx + dy * dy <= 32'(pm_join_dist)) begin
						hit = 1;
						c = k;
					end
				end
				if (hit) begin
					// min only moves when max did not
					if (d.r > tb_max_r[c]) tb_max_r[c] = d.r;
					else if (d.r < tb_min_r[c]) tb_min_r[c] = d.r;
					tb_sum_x[c] = sat21(tb_sum_x[c], d.x);
					tb_sum_y[c] = sat21(tb_sum_y[c], d.y);
					if (tb_members[c] != 11'h7FF) tb_members[c] = tb_members[c] + 11'd1;
					tb_err[c] = sat18(tb_err[c], d.e);
					tb_rad[c] = sat18(tb_rad[c], d.r);
					tb_cen_x[c] = 11'(tb_sum_x[c] / tb_members[c]);
					tb_cen_y[c] = 11'(tb_sum_y[c] / tb_members[c]);
					o.status = ST_JOIN;
					fill_cluster(o, c);
				end else if (open_cnt >= lim) begin
					halted = 1;
					o.status = ST_FULL;
				end else begin
					c = int'(open_cnt);
					tb_cen_x[c] = d.x;
					tb_cen_y[c] = d.y;
					tb_min_r[c] = d.r;
					tb_max_r[c] = d.r;
					tb_members[c] = 11'd1;
					tb_sum_x[c] = 21'(d.x);
					tb_sum_y[c] = 21'(d.y);
					tb_err[c] = 18'(d.e);
					tb_rad[c] = 18'(d.r);
					open_cnt++;
					o.status = ST_NEW;
					fill_cluster(o, c);
				end
			end
		end
		o.count = open_cnt[4:0];
		if (d.last) begin
			open_cnt = 0;
			halted = 0;
			frame_dets = 0;
		end
		return o;
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic wait_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// registers are only written with nothing in flight
	task automatic write_reg(logic idx, logic [15:0] val);
		det.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		wait_cycles(50);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_MAX_CLUSTERS) pm_max_clusters = val[4:0];
		else pm_join_dist = val;
	endtask

	// offers one detection; prediction is queued at acceptance
	// valid stays up after acceptance so back-to-back items need no gap
	task automatic send_det(det_t d, int gap, bit known = 0, clres_t want = '{default: '0});
		clres_t p;
		if (gap != 0) begin
			det.valid <= 1'b0;
			wait_cycles(gap);
		end
		det.valid         <= 1'b1;
		det.det_x         <= d.x;
		det.det_y         <= d.y;
		det.det_radius    <= d.r;
		det.det_error     <= d.e;
		det.last_of_frame <= d.last;
		@(posedge clk);
		while (!det.ready) @(posedge clk);
		p = cluster_step(d);
		if (known && p != want) begin
			$error("directed row: predictor disagrees with typed-in result");
			fail_count++;
		end
		pending_results.push_back(p);
		@(negedge clk);
	endtask

	function automatic det_t rand_det(int unsigned spread, bit last);
		det_t d;
		d.x = 11'($urandom_range(spread));
		d.y = 11'($urandom_range(spread));
		d.r = 8'($urandom);
		d.e = 8'($urandom);
		d.last = last;
		return d;
	endfunction

	// a frame of detections scattered around a few centers
	task automatic send_frame(int n, bit gaps);
		det_t d;
		logic [10:0] cx [4];
		logic [10:0] cy [4];
		int k;
		for (int i = 0; i < 4; i++) begin
			cx[i] = 11'($urandom_range(2047));
			cy[i] = 11'($urandom_range(2047));
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7) begin
				k = $urandom_range(3);
				d.x = 11'(cx[k] + $urandom_range(6) - 3);
				d.y = 11'(cy[k] + $urandom_range(6) - 3);
				d.r = 8'($urandom);
				d.e = 8'($urandom);
			end else begin
				d = rand_det(2047, 0);
			end
			d.last = (i == n - 1);
			send_det(d, gaps ? $urandom_range(19) : 0);
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	row_t dir_rows [$];

	function automatic row_t mk(int x, int y, int r, int e, bit last,
		bit known = 0, clres_t want = '{default: '0});
		row_t w;
		w.d = '{x: 11'(x), y: 11'(y), r: 8'(r), e: 8'(e), last: last};
		w.known = known;
		w.want = want;
		return w;
	endfunction

	initial begin
		det.valid = 1'b0;
		det.det_x = '0;
		det.det_y = '0;
		det.det_radius = '0;
		det.det_error = '0;
		det.last_of_frame = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_MAX_CLUSTERS;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_cycles(2);

		// first item after reset opens entry 0
		dir_rows.push_back(mk(0, 0, 0, 0, 0, 1,
			'{ST_NEW, 4'd0, 5'd1, 11'd0, 11'd0, 8'd0, 8'd0, 11'd1, 18'd0, 18'd0}));
		// joins entry 0 at distance sq 8, centroid 2/2 = 1
		dir_rows.push_back(mk(2, 2, 255, 255, 0, 1,
			'{ST_JOIN, 4'd0, 5'd1, 11'd1, 11'd1, 8'd0, 8'd255, 11'd2, 18'd255, 18'd255}));
		// far corner opens entry 1
		dir_rows.push_back(mk(2047, 2047, 255, 255, 0, 1,
			'{ST_NEW, 4'd1, 5'd2, 11'd2047, 11'd2047, 8'd255, 8'd255, 11'd1, 18'd255,
			18'd255}));
		dir_rows.push_back(mk(2043, 2047, 7, 1, 0));     // distance sq exactly 16 joins
		dir_rows.push_back(mk(1, 5, 100, 3, 0));         // distance sq 16 from entry 0, joins it
		dir_rows.push_back(mk(1024, 1023, 128, 128, 0));
		dir_rows.push_back(mk(1365, 682, 85, 170, 1));   // last of frame clears table
		// after frame end, a fresh entry 0
		dir_rows.push_back(mk(2047, 0, 1, 2, 0, 1,
			'{ST_NEW, 4'd0, 5'd1, 11'd2047, 11'd0, 8'd1, 8'd1, 11'd1, 18'd2, 18'd1}));
		dir_rows.push_back(mk(2045, 3, 0, 0, 1));
		foreach (dir_rows[i])
			send_det(dir_rows[i].d, $urandom_range(19), dir_rows[i].known, dir_rows[i].want);

		// single-entry table: first item fills it, second distinct item and rest of frame dropped
		write_reg(REG_MAX_CLUSTERS, 16'd1);
		write_reg(REG_JOIN_DIST, 16'd0);
		send_det('{x: 11'd5, y: 11'd5, r: 8'd9, e: 8'd9, last: 1'b0}, 0);
		send_det('{x: 11'd5, y: 11'd5, r: 8'd3, e: 8'd1, last: 1'b0}, 0);
		send_det('{x: 11'd6, y: 11'd5, r: 8'd3, e: 8'd1, last: 1'b0}, 0, 1,
			'{ST_FULL, 4'd0, 5'd1, 11'd0, 11'd0, 8'd0, 8'd0, 11'd0, 18'd0, 18'd0});
		send_det('{x: 11'd5, y: 11'd5, r: 8'd3, e: 8'd1, last: 1'b1}, 0, 1,
			'{ST_FULL, 4'd0, 5'd1, 11'd0, 11'd0, 8'd0, 8'd0, 11'd0, 18'd0, 18'd0});

		// zero entries: every frame halts at once
		write_reg(REG_MAX_CLUSTERS, 16'd0);
		send_det('{x: 11'd1, y: 11'd1, r: 8'd1, e: 8'd1, last: 1'b0}, 0, 1,
			'{ST_FULL, 4'd0, 5'd0, 11'd0, 11'd0, 8'd0, 8'd0, 11'd0, 18'd0, 18'd0});
		send_det('{x: 11'd1, y: 11'd1, r: 8'd1, e: 8'd1, last: 1'b1}, 0);

		// above the table size acts as the table size; widest join distance
		write_reg(REG_MAX_CLUSTERS, 16'd31);
		write_reg(REG_JOIN_DIST, 16'hFFFF);
		for (int i = 0; i < 4; i++) send_det(rand_det(2047, i == 3), $urandom_range(3));

		// frame limit: one frame longer than the detection limit, tight join
		write_reg(REG_MAX_CLUSTERS, 16'd16);
		write_reg(REG_JOIN_DIST, 16'd2);
		for (int i = 0; i < MAX_DETECTIONS + 3; i++)
			send_det(rand_det(i < 40 ? 2047 : 3, i == MAX_DETECTIONS + 2), 0);

		// random frames under varied settings; long sink hold-off on one phase
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MAX_CLUSTERS, ph == 0 ? 16'd1 : 16'($urandom_range(16)));
			write_reg(REG_JOIN_DIST, ph == 1 ? 16'hFFFF : (ph == 2 ? 16'd0
				: 16'($urandom_range(64))));
			if (ph == 3) hold_sink = 1;
			for (int f = 0; f < 2; f++) send_frame($urandom_range(1, 10), ph != 4);
			// sender pauses until every result has come
			if (ph == 5) begin
				det.valid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			if (ph == 6) begin
				for (int i = 0; i < 5; i++)
					send_det(rand_det(2047, $urandom_range(3) == 0), $urandom_range(19));
				send_det(rand_det(2047, 1), 0);
			end
		end

		det.valid <= 1'b0;
		stim_done = 1;
	end

	// ---------------------------------------------------------------- checking

	// sink side: random stalls, one long hold-off while items keep coming
	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				res.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_sink = 0;
			end
			stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		clres_t w;
		if (res.valid && res.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting");
				fail_count++;
			end else begin
				w = pending_results.pop_front();
				if (res.status !== w.status) begin
					$error("status exp %0d got %0d", w.status, res.status); fail_count++;
				end
				if (res.cluster_index !== w.index) begin
					$error("cluster_index exp %0d got %0d", w.index, res.cluster_index);
					fail_count++;
				end
				if (res.cluster_count !== w.count) begin
					$error("cluster_count exp %0d got %0d", w.count, res.cluster_count);
					fail_count++;
				end
				if (res.centroid_x !== w.cen_x) begin
					$error("centroid_x exp %0d got %0d", w.cen_x, res.centroid_x);
					fail_count++;
				end
				if (res.centroid_y !== w.cen_y) begin
					$error("centroid_y exp %0d got %0d", w.cen_y, res.centroid_y);
					fail_count++;
				end
				if (res.min_radius !== w.min_r) begin
					$error("min_radius exp %0d got %0d", w.min_r, res.min_radius);
					fail_count++;
				end
				if (res.max_radius !== w.max_r) begin
					$error("max_radius exp %0d got %0d", w.max_r, res.max_radius);
					fail_count++;
				end
				if (res.member_count !== w.members) begin
					$error("member_count exp %0d got %0d", w.members, res.member_count);
					fail_count++;
				end
				if (res.error_sum !== w.err_sum) begin
					$error("error_sum exp %0d got %0d", w.err_sum, res.error_sum);
					fail_count++;
				end
				if (res.radius_sum !== w.rad_sum) begin
					$error("radius_sum exp %0d got %0d", w.rad_sum, res.radius_sum);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake on the detection, result or register port, plus the end of run
	always @(posedge clk) begin
		if ((det.valid && det.ready) || (res.valid && res.ready)
			|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
